[sv/avr_pkg.sv]
`default_nettype none
package avr_pkg;
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned AxisWidthDef = 16;
  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AngTableLen = 24;
  localparam int unsigned AngleWidth = 16;
  localparam int unsigned Mfrac = 28;
  localparam int signed FullTurn = 23040;
  localparam int signed HalfTurn = 11520;
  localparam int signed QuarterTurn = 5760;
  localparam logic signed [33:0] InvGain = 34'sd652032874;
  // Width of the CORDIC datapath (Q2.30 plus guard bits).
  localparam int unsigned CordW = 34;
  localparam int unsigned ZW = 32;
  // Matrix entries need headroom above Q4.28 when the axis sits at its most
  // negative code.
  localparam int unsigned MW = 34;

  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      0: r = 32'sd188743680;  1: r = 32'sd111421900; 2: r = 32'sd58872272;
      3: r = 32'sd29884485;   4: r = 32'sd15000234;  5: r = 32'sd7507429;
      6: r = 32'sd3754631;    7: r = 32'sd1877430;   8: r = 32'sd938729;
      9: r = 32'sd469366;     10: r = 32'sd234683;   11: r = 32'sd117342;
      12: r = 32'sd58671;     13: r = 32'sd29335;    14: r = 32'sd14668;
      15: r = 32'sd7334;      16: r = 32'sd3667;     17: r = 32'sd1833;
      18: r = 32'sd917;       19: r = 32'sd458;      20: r = 32'sd229;
      21: r = 32'sd115;       22: r = 32'sd57;       23: r = 32'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

[sv/avr_in_if.sv]
`default_nettype none
interface avr_in_if #(
  parameter int unsigned CW = 32,
  parameter int unsigned AW = 16
);
  logic valid;
  logic ready;
  logic signed [CW-1:0] vec_x;
  logic signed [CW-1:0] vec_y;
  logic signed [CW-1:0] vec_z;
  logic signed [AW-1:0] axis_x;
  logic signed [AW-1:0] axis_y;
  logic signed [AW-1:0] axis_z;
  logic signed [15:0] angle_deg;
  modport source(output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
                 input ready);
  modport sink(input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
               output ready);
endinterface
`default_nettype wire

[sv/avr_out_if.sv]
`default_nettype none
interface avr_out_if #(
  parameter int unsigned CW = 32
);
  logic valid;
  logic ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  modport source(output valid, out_x, out_y, out_z, input ready);
  modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

[sv/axis_angle_vector_rotate.sv]
`default_nettype none
// Axis-angle (Rodrigues) vector rotation.
// The in_if sink channel carries one transaction per vector: the vector in
// signed Q16.16, a unit axis in signed Q1.14 (not normalized here) and an
// angle in 1/64 degree. The out_if source channel returns one transaction
// with the rotated vector, saturated, in the vector's format. The matrix
// uses the transposed sine sign convention of the off-diagonal terms.
// The design is a single pipeline: angle fold, the CORDIC stages,
// sine/cosine rounding, axis products, products times (1 - cos), matrix
// assembly, then three parallel dot-product lanes (one per output) that
// merge at the output register. An accepted transaction passes through
// these stage registers in order and is shown on out_if from the output
// register; throughput is one transaction per cycle while out_if is not
// stalled.
// The whole pipeline advances together when the output register is empty
// or being taken, so a stall on the out side holds every stage and drops
// in.ready; nothing is lost. Reset clears only the valid bits of the stages.
module axis_angle_vector_rotate
  import avr_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned AXIS_WIDTH = AxisWidthDef,
  parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  avr_in_if.sink   in_if,
  avr_out_if.source out_if
);
  localparam int unsigned NS = (CORDIC_STAGES < AngTableLen) ? CORDIC_STAGES : AngTableLen;
  localparam int unsigned Lat = NS + 7;
  localparam int unsigned AxSh = Mfrac - (AXIS_WIDTH - 2);
  localparam int unsigned SideW = 3 * COORD_WIDTH + 3 * AXIS_WIDTH;

  logic en;
  logic [Lat-1:0] vld_q;

  // The final valid bit is the output register.
  assign en = !vld_q[Lat-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_if.valid};
    end
  end
  assign out_if.valid = vld_q[Lat-1];

  // Side data (vector and axis) delayed alongside the CORDIC. Entry k lines
  // up with CORDIC register k.
  logic [SideW-1:0] side_q [NS+4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= {in_if.vec_x, in_if.vec_y, in_if.vec_z,
                    in_if.axis_x, in_if.axis_y, in_if.axis_z};
      for (int k = 1; k < NS + 4; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Stage 0: angle reduction. Remainder by 23040 of a 16-bit value: the
  // magnitude is at most 2^15, so at most one +/- 23040 step is needed.
  logic signed [16:0] r0, r1, r2;
  logic flip_d;
  logic signed [15:0] r_d;
  always_comb begin
    r0 = 17'(in_if.angle_deg);
    if (r0 >= 17'(FullTurn)) r1 = r0 - 17'(FullTurn);
    else if (r0 <= -17'(FullTurn)) r1 = r0 + 17'(FullTurn);
    else r1 = r0;
    if (r1 < 0) r2 = r1 + 17'(FullTurn); else r2 = r1;
    if (r2 > 17'(HalfTurn)) r2 = r2 - 17'(FullTurn);
    flip_d = 1'b0;
    if (r2 > 17'(QuarterTurn)) begin
      r2 = r2 - 17'(HalfTurn);
      flip_d = 1'b1;
    end else if (r2 < -17'(QuarterTurn)) begin
      r2 = r2 + 17'(HalfTurn);
      flip_d = 1'b1;
    end
    r_d = 16'(r2);
  end

  logic signed [CordW-1:0] cx [NS+1];
  logic signed [CordW-1:0] cy [NS+1];
  logic signed [ZW-1:0] cz [NS+1];
  logic [NS:0] flip_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx[0] <= InvGain;
      cy[0] <= '0;
      cz[0] <= ZW'(r_d) <<< 16;
      flip_q <= {flip_q[NS-1:0], flip_d};
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_cordic
    avr_cordic_stage #(.Idx(g)) u_stage (
      .clk_i(clk_i), .en_i(en),
      .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1])
    );
  end

  // Post-CORDIC: sign fold, rounding to Q.28 and 1 - cos, registered.
  logic signed [MW-1:0] c_q, s_q, t_q;
  logic signed [CordW-1:0] fx, fy;
  assign fx = flip_q[NS] ? -cx[NS] : cx[NS];
  assign fy = flip_q[NS] ? -cy[NS] : cy[NS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= MW'((fx + CordW'(2)) >>> 2);
      s_q <= MW'((fy + CordW'(2)) >>> 2);
      t_q <= MW'((34'sd1 <<< Mfrac) - ((fx + CordW'(2)) >>> 2));
    end
  end

  // Axis products and axis*sine, registered.
  logic signed [MW-1:0] pp_q [6];
  logic signed [MW-1:0] as_q [3];
  logic signed [MW-1:0] c2_q, t2_q;
  logic signed [MW-1:0] av [3];
  logic [SideW-1:0] sd2;
  assign sd2 = side_q[NS+1];
  assign av[0] = MW'($signed(sd2[3*AXIS_WIDTH-1:2*AXIS_WIDTH])) <<< AxSh;
  assign av[1] = MW'($signed(sd2[2*AXIS_WIDTH-1:AXIS_WIDTH])) <<< AxSh;
  assign av[2] = MW'($signed(sd2[AXIS_WIDTH-1:0])) <<< AxSh;

  function automatic logic signed [MW-1:0] mulr(input logic signed [MW-1:0] a,
                                               input logic signed [MW-1:0] b);
    logic signed [2*MW-1:0] p;
    p = (2*MW)'(a) * (2*MW)'(b) + ((2*MW)'(1) <<< (Mfrac - 1));
    return MW'(p >>> Mfrac);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_q[0] <= mulr(av[0], av[0]);
      pp_q[1] <= mulr(av[0], av[1]);
      pp_q[2] <= mulr(av[0], av[2]);
      pp_q[3] <= mulr(av[1], av[1]);
      pp_q[4] <= mulr(av[1], av[2]);
      pp_q[5] <= mulr(av[2], av[2]);
      as_q[0] <= mulr(av[0], s_q);
      as_q[1] <= mulr(av[1], s_q);
      as_q[2] <= mulr(av[2], s_q);
      c2_q <= c_q;
      t2_q <= t_q;
    end
  end

  // Products times t, registered, then matrix assembly.
  logic signed [MW-1:0] pt_q [6];
  logic signed [MW-1:0] as3_q [3];
  logic signed [MW-1:0] c3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) pt_q[k] <= mulr(pp_q[k], t2_q);
      as3_q <= as_q;
      c3_q <= c2_q;
    end
  end

  logic signed [MW-1:0] m_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q[0] <= pt_q[0] + c3_q;
      m_q[1] <= pt_q[1] + as3_q[2];
      m_q[2] <= pt_q[2] - as3_q[1];
      m_q[3] <= pt_q[1] - as3_q[2];
      m_q[4] <= pt_q[3] + c3_q;
      m_q[5] <= pt_q[4] + as3_q[0];
      m_q[6] <= pt_q[2] + as3_q[1];
      m_q[7] <= pt_q[4] - as3_q[0];
      m_q[8] <= pt_q[5] + c3_q;
    end
  end

  // Vector aligned to the matrix.
  logic signed [COORD_WIDTH-1:0] vq [3];
  logic [SideW-1:0] sdv_q;
  always_ff @(posedge clk_i) begin
    if (en) sdv_q <= side_q[NS+3];
  end
  assign vq[0] = $signed(sdv_q[SideW-1 -: COORD_WIDTH]);
  assign vq[1] = $signed(sdv_q[SideW-COORD_WIDTH-1 -: COORD_WIDTH]);
  assign vq[2] = $signed(sdv_q[SideW-2*COORD_WIDTH-1 -: COORD_WIDTH]);

  logic signed [COORD_WIDTH-1:0] res [3];
  for (genvar l = 0; l < 3; l++) begin : g_lane
    avr_lane #(.CoordWidth(COORD_WIDTH)) u_lane (
      .clk_i(clk_i), .en_i(en),
      .v0_i(vq[0]), .v1_i(vq[1]), .v2_i(vq[2]),
      .m0_i(m_q[3*l]), .m1_i(m_q[3*l+1]), .m2_i(m_q[3*l+2]),
      .res_o(res[l])
    );
  end

  assign out_if.out_x = res[0];
  assign out_if.out_y = res[1];
  assign out_if.out_z = res[2];
endmodule
`default_nettype wire

[sv/avr_cordic_stage.sv]
`default_nettype none
// One pipelined CORDIC micro-rotation with its register.
module avr_cordic_stage
  import avr_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic signed [CordW-1:0] x_i,
  input  wire logic signed [CordW-1:0] y_i,
  input  wire logic signed [ZW-1:0]    z_i,
  output logic signed [CordW-1:0]      x_o,
  output logic signed [CordW-1:0]      y_o,
  output logic signed [ZW-1:0]         z_o
);
  logic signed [CordW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  assign dx = y_i >>> Idx;
  assign dy = x_i >>> Idx;
  assign at = atan_tab(Idx);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!z_i[ZW-1]) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - at;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + at;
      end
    end
  end
endmodule
`default_nettype wire

[sv/avr_lane.sv]
`default_nettype none
// One output lane: dot product of the vector with one matrix row, rounded and
// saturated. Split multiply: high and low vector parts, two pipeline stages.
module avr_lane
  import avr_pkg::*;
#(
  parameter int unsigned CoordWidth = CoordWidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic signed [CoordWidth-1:0] v0_i,
  input  wire logic signed [CoordWidth-1:0] v1_i,
  input  wire logic signed [CoordWidth-1:0] v2_i,
  input  wire logic signed [MW-1:0]         m0_i,
  input  wire logic signed [MW-1:0]         m1_i,
  input  wire logic signed [MW-1:0]         m2_i,
  output logic signed [CoordWidth-1:0]      res_o
);
  localparam int unsigned LoW = 24;
  localparam int unsigned HiW = (CoordWidth > LoW) ? CoordWidth - LoW : 1;
  localparam int unsigned PW = HiW + MW + 3;
  localparam int unsigned LW = LoW + 1 + MW + 2;
  localparam int unsigned SW = PW + LoW + 2;

  logic signed [PW-1:0] hi_q;
  logic signed [LW-1:0] lo_q;
  logic signed [HiW-1:0] vh [3];
  logic signed [LoW:0] vl [3];
  logic signed [MW-1:0] mm [3];
  logic signed [SW-1:0] tot, rnd;
  logic signed [SW-Mfrac-1:0] q;
  logic signed [SW-Mfrac-1:0] lim_hi, lim_lo;

  assign mm[0] = m0_i;
  assign mm[1] = m1_i;
  assign mm[2] = m2_i;

  always_comb begin
    logic signed [SW-1:0] vv;
    for (int j = 0; j < 3; j++) begin
      vv = (j == 0) ? SW'(v0_i) : (j == 1) ? SW'(v1_i) : SW'(v2_i);
      if (CoordWidth > LoW) begin
        vh[j] = HiW'(vv >>> LoW);
        vl[j] = {1'b0, vv[LoW-1:0]};
      end else begin
        vh[j] = '0;
        vl[j] = (LoW+1)'(vv);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q <= PW'(vh[0] * mm[0]) + PW'(vh[1] * mm[1]) + PW'(vh[2] * mm[2]);
      lo_q <= LW'(vl[0] * mm[0]) + LW'(vl[1] * mm[1]) + LW'(vl[2] * mm[2]);
    end
  end

  assign tot = (SW'(hi_q) <<< LoW) + SW'(lo_q);
  assign rnd = tot + (SW'(1) <<< (Mfrac - 1));
  assign q = (SW-Mfrac)'(rnd >>> Mfrac);
  assign lim_hi = (SW-Mfrac)'({1'b0, {(CoordWidth-1){1'b1}}});
  assign lim_lo = -lim_hi - (SW-Mfrac)'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (q > lim_hi) res_o <= {1'b0, {(CoordWidth-1){1'b1}}};
      else if (q < lim_lo) res_o <= {1'b1, {(CoordWidth-1){1'b0}}};
      else res_o <= CoordWidth'(q);
    end
  end
endmodule
`default_nettype wire

[sv/avr_checker.sv]
`default_nettype none
module avr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [95:0] out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn while waiting");
endmodule
bind axis_angle_vector_rotate avr_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_data({out_if.out_x, out_if.out_y, out_if.out_z})
);
`default_nettype wire
